### rtl/psrmc_pkg.sv
// Package for the per-slave register mirror cache.
// Holds default sizes and result status codes; depends on nothing.
`timescale 1ns / 1ps

package psrmc_pkg;

  localparam int SlaveSlotsDefault      = 16;
  localparam int EntriesPerSlaveDefault = 16;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_MISS     = 3'd2,
    ST_NO_SLOT  = 3'd3,
    ST_IGNORED  = 3'd4
  } psrmc_status_t;

endpackage

### rtl/psrmc_ram.sv
// Generic RAM with one write port and one registered read port.
// Standalone; used for all stores of the mirror cache.
`timescale 1ns / 1ps

module psrmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/per_slave_register_mirror_cache.sv
// Top level of the per-slave register mirror cache: slave tag scan, entry scan
// and the sequencer around them. Depends on psrmc_pkg and psrmc_ram.
//
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   tuser: func; tdata: dev_addr .. write_value
//   m_*       out        m_tvalid/m_tready   tdata: status, read_value
//
// A request passes through idle, a tag scan over the slaves in use, a count read
// and latch (skipped for a new slave), an entry scan over that slave's entries and
// out; one compare walks the tag RAM, another the entry RAM. An update with an index
// beyond its run goes from idle straight to out. Reset is synchronous and clears the
// state, the slave count and m_tvalid; no RAM is cleared. s_tready is high only while
// idle, and a result waits in the output register until m_tready takes it.
`timescale 1ns / 1ps

module per_slave_register_mirror_cache
  import psrmc_pkg::*;
#(
  parameter int SLAVE_SLOTS       = SlaveSlotsDefault,
  parameter int ENTRIES_PER_SLAVE = EntriesPerSlaveDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // dev_addr[7:0], reg_addr[23:8], word_index[30:24], word_count[37:31],
  // write_value[53:38], zero[55:54]
  input  logic [55:0] s_tdata,
  // func[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], read_value[18:3], zero[23:19]
  output logic [23:0] m_tdata
);

  localparam int SW = SLAVE_SLOTS > 1 ? $clog2(SLAVE_SLOTS) : 1;
  localparam int UW = $clog2(SLAVE_SLOTS + 1);
  localparam int CW = $clog2(ENTRIES_PER_SLAVE + 1);
  localparam int FLAT = SLAVE_SLOTS * ENTRIES_PER_SLAVE;
  localparam int AW = FLAT > 1 ? $clog2(FLAT) : 1;
  localparam logic [UW-1:0] SLOTS_U = UW'(SLAVE_SLOTS);
  localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES_PER_SLAVE);
  localparam logic [AW-1:0] ENTRIES_A = AW'(ENTRIES_PER_SLAVE);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TSCAN = 6'b000010,
    S_CRD   = 6'b000100,
    S_CLAT  = 6'b001000,
    S_ESCAN = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t        state;
  logic [UW-1:0] used;
  logic          func_q;
  logic [7:0]    sid_q;
  logic [15:0]   reg_q;
  logic [15:0]   wval_q;
  logic [UW-1:0] i_cnt;
  logic          pend;
  logic [SW-1:0] pend_idx;
  logic [SW-1:0] slot;
  logic [AW-1:0] base;
  logic [CW-1:0] cnt;
  logic [CW-1:0] j_cnt;
  logic          epend;
  logic [AW-1:0] epend_addr;
  psrmc_status_t status_q;
  logic [15:0]   value_q;

  logic [7:0]    tag_rd;
  logic [CW-1:0] cnt_rd;
  logic [31:0]   ent_rd;
  logic          tag_hit;
  logic          t_more;
  logic          t_new;
  logic          ent_hit;
  logic          e_more;
  logic          e_insert;
  logic          tag_we;
  logic          cnt_we;
  logic [SW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic          ent_we;
  logic [AW-1:0] ent_waddr;
  logic [AW-1:0] ent_raddr;

  logic [7:0]    in_sid;
  logic [15:0]   in_reg;
  logic [6:0]    in_idx;
  logic [6:0]    in_count;
  logic [15:0]   in_wval;

  assign in_sid   = s_tdata[7:0];
  assign in_reg   = s_tdata[23:8];
  assign in_idx   = s_tdata[30:24];
  assign in_count = s_tdata[37:31];
  assign in_wval  = s_tdata[53:38];

  assign s_tready = (state == S_IDLE);

  always_comb begin
    tag_hit   = pend && (tag_rd == sid_q);
    t_more    = i_cnt < used;
    t_new     = (state == S_TSCAN) && !tag_hit && !t_more && (used < SLOTS_U);
    tag_we    = t_new;
    ent_hit   = epend && (ent_rd[15:0] == reg_q);
    e_more    = j_cnt < cnt;
    e_insert  = (state == S_ESCAN) && !ent_hit && !e_more && !func_q && (cnt < ENTRIES_C);
    ent_raddr = base + AW'(j_cnt);
    ent_we    = ((state == S_ESCAN) && ent_hit && !func_q) || e_insert;
    ent_waddr = ent_hit ? epend_addr : base + AW'(cnt);
    cnt_we    = t_new || e_insert;
    cnt_waddr = t_new ? SW'(used) : slot;
    cnt_wdata = t_new ? '0 : CW'(cnt + 1'b1);
  end

  psrmc_ram #(.WIDTH(8), .DEPTH(SLAVE_SLOTS)) u_tags (
    .clk   (clk),
    .we    (tag_we),
    .waddr (SW'(used)),
    .wdata (sid_q),
    .raddr (SW'(i_cnt)),
    .rdata (tag_rd)
  );

  psrmc_ram #(.WIDTH(CW), .DEPTH(SLAVE_SLOTS)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (slot),
    .rdata (cnt_rd)
  );

  psrmc_ram #(.WIDTH(32), .DEPTH(FLAT)) u_entries (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata ({wval_q, reg_q}),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func_q  <= s_tuser;
            sid_q   <= in_sid;
            reg_q   <= s_tuser ? in_reg : in_reg + {9'd0, in_idx};
            wval_q  <= in_wval;
            i_cnt   <= '0;
            pend    <= 1'b0;
            value_q <= '0;
            if (!s_tuser && (in_idx >= in_count)) begin
              status_q <= ST_IGNORED;
              state    <= S_OUT;
            end else begin
              state <= S_TSCAN;
            end
          end
        end
        S_TSCAN: begin
          if (tag_hit) begin
            slot  <= pend_idx;
            base  <= AW'(pend_idx) * ENTRIES_A;
            state <= S_CRD;
          end else if (t_more) begin
            pend     <= 1'b1;
            pend_idx <= SW'(i_cnt);
            i_cnt    <= i_cnt + 1'b1;
          end else if (used < SLOTS_U) begin
            slot  <= SW'(used);
            base  <= AW'(used) * ENTRIES_A;
            used  <= used + 1'b1;
            cnt   <= '0;
            j_cnt <= '0;
            epend <= 1'b0;
            state <= S_ESCAN;
          end else begin
            status_q <= ST_NO_SLOT;
            state    <= S_OUT;
          end
        end
        S_CRD: begin
          state <= S_CLAT;
        end
        S_CLAT: begin
          cnt   <= cnt_rd;
          j_cnt <= '0;
          epend <= 1'b0;
          state <= S_ESCAN;
        end
        S_ESCAN: begin
          if (ent_hit) begin
            status_q <= ST_HIT;
            value_q  <= func_q ? ent_rd[31:16] : 16'd0;
            state    <= S_OUT;
          end else if (e_more) begin
            epend      <= 1'b1;
            epend_addr <= ent_raddr;
            j_cnt      <= j_cnt + 1'b1;
          end else begin
            status_q <= e_insert ? ST_INSERTED : ST_MISS;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {5'd0, value_q, status_q};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### test/tb.sv
// Self-checking testbench for per_slave_register_mirror_cache: a directed table,
// then random update runs, lookups and noise, checked against a predictor in this file.
// Depends on psrmc_pkg and the RTL of the mirror cache.
`timescale 1ns / 1ps

module tb;
  import psrmc_pkg::*;

  localparam int Slots       = SlaveSlotsDefault;
  localparam int Entries     = EntriesPerSlaveDefault;
  localparam logic FN_UPDATE = 1'b0;
  localparam logic FN_LOOKUP = 1'b1;
  localparam int TotalItems  = 1550;
  localparam int MaxReports  = 10;
  localparam int DrainCycles = Slots + Entries + 16;
  localparam int PressureAt  = 400;
  localparam int PressureLen = 300;
  localparam int DirectedLen = 26;

  typedef struct packed {
    logic        func;
    logic [7:0]  dev_addr;
    logic [15:0] reg_addr;
    logic [6:0]  word_index;
    logic [6:0]  word_count;
    logic [15:0] write_value;
  } mirror_req_t;

  typedef struct packed {
    psrmc_status_t status;
    logic [15:0]   read_value;
  } mirror_result_t;

  typedef struct packed {
    mirror_req_t    req;
    logic           typed;
    mirror_result_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  per_slave_register_mirror_cache u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Mirror state as the block should hold it.
  int unsigned slaves_in_use = 0;
  logic [7:0]  slot_ids [Slots];
  int unsigned slot_fill [Slots];
  logic [15:0] mirror_regs [Slots][Entries];
  logic [15:0] mirror_vals [Slots][Entries];

  mirror_result_t pending_results [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit calm = 1'b0;

  logic [7:0]  known_ids [Slots] = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                                     8'h40, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h3C, 8'hC3};
  logic [15:0] start_bases [4] = '{16'h0000, 16'hFFFC, 16'h0040, 16'h8000};

  directed_row_t directed_rows [DirectedLen] = '{
    '{'{FN_LOOKUP, 8'h00, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_UPDATE, 8'h00, 16'h1234, 7'h00, 7'h00, 16'hFFFF}, 1'b1, '{ST_IGNORED, 16'h0000}},
    '{'{FN_UPDATE, 8'h55, 16'h0000, 7'h7F, 7'h7F, 16'h0000}, 1'b1, '{ST_IGNORED, 16'h0000}},
    '{'{FN_UPDATE, 8'h00, 16'hFFFF, 7'h7E, 7'h7F, 16'hA5A5}, 1'b1, '{ST_INSERTED, 16'h0000}},
    '{'{FN_UPDATE, 8'hFF, 16'hFFFF, 7'h01, 7'h02, 16'hFFFF}, 1'b1, '{ST_INSERTED, 16'h0000}},
    '{'{FN_LOOKUP, 8'hFF, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_HIT, 16'hFFFF}},
    '{'{FN_LOOKUP, 8'h00, 16'h007D, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_HIT, 16'hA5A5}},
    '{'{FN_UPDATE, 8'hFF, 16'h0000, 7'h00, 7'h01, 16'h0000}, 1'b1, '{ST_HIT, 16'h0000}},
    '{'{FN_LOOKUP, 8'hFF, 16'hFFFF, 7'h7F, 7'h7F, 16'hFFFF}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_UPDATE, 8'h00, 16'h0000, 7'h7C, 7'h7D, 16'h5A5A}, 1'b0, '{ST_HIT, 16'h0000}},
    '{'{FN_UPDATE, 8'h01, 16'hFFFF, 7'h00, 7'h7D, 16'h8001}, 1'b0, '{ST_HIT, 16'h0000}},
    '{'{FN_LOOKUP, 8'h02, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'h04, 16'hFFFF, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'h08, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'h10, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'h20, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'h40, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'h80, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'h55, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'hAA, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'h7F, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'hFE, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'h3C, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_LOOKUP, 8'hC3, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_MISS, 16'h0000}},
    '{'{FN_UPDATE, 8'h99, 16'h0000, 7'h00, 7'h01, 16'h1111}, 1'b1, '{ST_NO_SLOT, 16'h0000}},
    '{'{FN_LOOKUP, 8'h66, 16'h0000, 7'h00, 7'h00, 16'h0000}, 1'b1, '{ST_NO_SLOT, 16'h0000}}
  };

  function automatic int slot_of(logic [7:0] id);
    for (int i = 0; i < int'(slaves_in_use); i++) begin
      if (slot_ids[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int entry_of(int slot, logic [15:0] target);
    for (int j = 0; j < int'(slot_fill[slot]); j++) begin
      if (mirror_regs[slot][j] == target) return j;
    end
    return -1;
  endfunction

  function automatic mirror_result_t apply_to_mirror(mirror_req_t q);
    mirror_result_t res;
    int slot;
    int hit;
    logic [15:0] target;
    res.status = ST_MISS;
    res.read_value = '0;
    if (q.func == FN_UPDATE && q.word_index >= q.word_count) begin
      res.status = ST_IGNORED;
      return res;
    end
    target = (q.func == FN_UPDATE) ? q.reg_addr + 16'(q.word_index) : q.reg_addr;
    slot = slot_of(q.dev_addr);
    if (slot < 0 && slaves_in_use < Slots) begin
      slot = int'(slaves_in_use);
      slot_ids[slot] = q.dev_addr;
      slot_fill[slot] = 0;
      slaves_in_use++;
    end
    if (slot < 0) begin
      res.status = ST_NO_SLOT;
      return res;
    end
    hit = entry_of(slot, target);
    if (q.func == FN_LOOKUP) begin
      if (hit >= 0) begin
        res.status = ST_HIT;
        res.read_value = mirror_vals[slot][hit];
      end
    end else if (hit >= 0) begin
      mirror_vals[slot][hit] = q.write_value;
      res.status = ST_HIT;
    end else if (slot_fill[slot] < Entries) begin
      mirror_regs[slot][slot_fill[slot]] = target;
      mirror_vals[slot][slot_fill[slot]] = q.write_value;
      slot_fill[slot]++;
      res.status = ST_INSERTED;
    end
    return res;
  endfunction

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic log_failure(string msg);
    errors++;
    if (errors <= MaxReports) $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic send_req(mirror_req_t q, logic typed, mirror_result_t want);
    mirror_result_t predicted;
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= q.func;
    s_tdata <= {2'b00, q.write_value, q.word_count, q.word_index, q.reg_addr, q.dev_addr};
    do @(posedge clk); while (!s_tready);
    predicted = apply_to_mirror(q);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  always @(posedge clk) begin : check_results
    mirror_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        log_failure($sformatf("result with nothing pending: status %0d value %h",
                              m_tdata[2:0], m_tdata[18:3]));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[2:0] != want.status)
          log_failure($sformatf("status: expected %0d, got %0d", want.status, m_tdata[2:0]));
        if (m_tdata[18:3] != want.read_value)
          log_failure($sformatf("read_value: expected %h, got %h",
                                want.read_value, m_tdata[18:3]));
      end
    end
  end

  initial begin : result_sink
    int stall;
    bit pressure_done;
    stall = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && results_seen >= PressureAt) begin
        pressure_done = 1'b1;
        stall = PressureLen;
      end
      if (stall == 0 && $urandom_range(0, 3) == 0) stall = idle_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    mirror_req_t q;
    mirror_result_t no_want;
    int pick;
    int slot;
    int run_len;
    int drain_wait;
    logic [15:0] base;
    no_want = '{ST_HIT, 16'h0000};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirectedLen; i++) begin
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    while (items_sent < TotalItems) begin
      if ($urandom_range(0, 49) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        q.func = FN_UPDATE;
        q.dev_addr = known_ids[$urandom_range(0, Slots - 1)];
        if ($urandom_range(0, 9) < 8) base = start_bases[$urandom_range(0, 3)]
                                             + 16'($urandom_range(0, 3));
        else base = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 80) run_len = $urandom_range(1, 6);
        else if (pick < 97) run_len = $urandom_range(7, 24);
        else run_len = $urandom_range(100, 125);
        q.reg_addr = base;
        q.word_count = 7'(run_len);
        for (int k = 0; k < run_len; k++) begin
          q.word_index = 7'(k);
          q.write_value = 16'($urandom);
          if ($urandom_range(0, 39) == 0) q.word_index = 7'($urandom_range(run_len, 127));
          send_req(q, 1'b0, no_want);
        end
      end else if (pick < 85) begin
        q.func = FN_LOOKUP;
        q.dev_addr = known_ids[$urandom_range(0, Slots - 1)];
        q.word_index = 7'($urandom);
        q.word_count = 7'($urandom);
        q.write_value = 16'($urandom);
        slot = slot_of(q.dev_addr);
        if (slot >= 0 && slot_fill[slot] > 0 && $urandom_range(0, 9) < 7)
          q.reg_addr = mirror_regs[slot][$urandom_range(0, slot_fill[slot] - 1)];
        else
          q.reg_addr = start_bases[$urandom_range(0, 3)] + 16'($urandom_range(0, 12));
        send_req(q, 1'b0, no_want);
      end else begin
        q.func = 1'($urandom_range(0, 1));
        q.dev_addr = 8'($urandom);
        q.reg_addr = 16'($urandom);
        q.word_index = 7'($urandom);
        q.word_count = 7'($urandom);
        q.write_value = 16'($urandom);
        send_req(q, 1'b0, no_want);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0)
      log_failure($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

### per_slave_register_mirror_cache.f
rtl/psrmc_pkg.sv
rtl/psrmc_ram.sv
rtl/per_slave_register_mirror_cache.sv
test/tb.sv
